// ===== rtl/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg
// Shared widths, register codes, reset values and the configuration
// record of the PI duty controller.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int SAMPLE_BITS = 12;

    localparam int TARGET_W = 12;
    localparam int GAIN_W   = 8;
    localparam int SHIFT_W  = 4;
    localparam int LIMIT_W  = 15;
    localparam int DUTY_W   = 10;
    localparam int THRESH_W = 12;
    localparam int ACC_W    = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // compare width for sample against target and threshold
    localparam int CMP_W   = (SAMPLE_BITS > TARGET_W) ? SAMPLE_BITS : TARGET_W;
    localparam int ERR_W   = CMP_W + 1;
    localparam int ASUM_W  = ((ERR_W > ACC_W) ? ERR_W : ACC_W) + 1;
    localparam int PPROD_W = ERR_W + GAIN_W + 1;
    localparam int IPROD_W = ACC_W + GAIN_W + 1;
    localparam int WSUM_W  = ((PPROD_W > IPROD_W) ? PPROD_W : IPROD_W) + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TARGET_LEVEL     = 3'd0,
        REG_PROP_GAIN        = 3'd1,
        REG_INTEG_GAIN       = 3'd2,
        REG_FRAC_SHIFT       = 3'd3,
        REG_INTEG_LIMIT      = 3'd4,
        REG_DUTY_MAX         = 3'd5,
        REG_STATUS_THRESHOLD = 3'd6
    } pdc_reg_idx_t;

    localparam logic [TARGET_W-1:0] TARGET_RST = 12'd2048;
    localparam logic [GAIN_W-1:0]   PGAIN_RST  = 8'd60;
    localparam logic [GAIN_W-1:0]   IGAIN_RST  = 8'd4;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 4'd8;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd5000;
    localparam logic [DUTY_W-1:0]   DUTY_RST   = 10'd950;
    localparam logic [THRESH_W-1:0] THRESH_RST = 12'd1948;

    typedef struct packed {
        logic [TARGET_W-1:0] target_level;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [SHIFT_W-1:0]  frac_shift;
        logic [LIMIT_W-1:0]  integ_limit;
        logic [DUTY_W-1:0]   duty_max;
        logic [THRESH_W-1:0] status_threshold;
    } pdc_cfg_t;

endpackage

// ===== rtl/pdc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pdc_cfg_regs
// Configuration register file; decodes one write word per accepted write.
// ----------------------------------------------------------------------------
module pdc_cfg_regs
    import pdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output pdc_cfg_t               cfg
);

    pdc_cfg_t cfg_reg;
    pdc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (pdc_reg_idx_t'(wr_index))
                REG_TARGET_LEVEL:     cfg_next.target_level     = wr_data[TARGET_W-1:0];
                REG_PROP_GAIN:        cfg_next.prop_gain        = wr_data[GAIN_W-1:0];
                REG_INTEG_GAIN:       cfg_next.integ_gain       = wr_data[GAIN_W-1:0];
                REG_FRAC_SHIFT:       cfg_next.frac_shift       = wr_data[SHIFT_W-1:0];
                REG_INTEG_LIMIT:      cfg_next.integ_limit      = wr_data[LIMIT_W-1:0];
                REG_DUTY_MAX:         cfg_next.duty_max         = wr_data[DUTY_W-1:0];
                REG_STATUS_THRESHOLD: cfg_next.status_threshold = wr_data[THRESH_W-1:0];
                default:              cfg_next = cfg_reg; // drop unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_level     <= TARGET_RST;
            cfg_reg.prop_gain        <= PGAIN_RST;
            cfg_reg.integ_gain       <= IGAIN_RST;
            cfg_reg.frac_shift       <= SHIFT_RST;
            cfg_reg.integ_limit      <= LIMIT_RST;
            cfg_reg.duty_max         <= DUTY_RST;
            cfg_reg.status_threshold <= THRESH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pdc_law.sv =====
// ----------------------------------------------------------------------------
// pdc_law
// Control law: error, clamped integral, weighted sum, floor shift, duty clamp, status compare.
// ----------------------------------------------------------------------------
module pdc_law
    import pdc_pkg::*;
(
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic signed [ACC_W-1:0] acc_in,
    input  pdc_cfg_t               cfg,
    output logic signed [ACC_W-1:0] acc_out,
    output logic [DUTY_W-1:0]      duty,
    output logic                   status
);

    logic signed [ERR_W-1:0]   err;
    logic signed [ASUM_W-1:0]  acc_sum;
    logic signed [ASUM_W-1:0]  lim_pos;
    logic signed [ASUM_W-1:0]  lim_neg;
    logic signed [ASUM_W-1:0]  acc_clamp;
    logic signed [PPROD_W-1:0] prod_p;
    logic signed [IPROD_W-1:0] prod_i;
    logic signed [WSUM_W-1:0]  wsum;
    logic signed [WSUM_W-1:0]  shifted;
    logic signed [WSUM_W-1:0]  duty_lim;

    always_comb
    begin
        err = $signed({1'b0, CMP_W'(cfg.target_level)}) - $signed({1'b0, CMP_W'(sample)});

        acc_sum = ASUM_W'(acc_in) + ASUM_W'(err);
        lim_pos = $signed(ASUM_W'({1'b0, cfg.integ_limit}));
        lim_neg = -lim_pos;
        if (acc_sum > lim_pos)
            acc_clamp = lim_pos;
        else if (acc_sum < lim_neg)
            acc_clamp = lim_neg;
        else
            acc_clamp = acc_sum;
        acc_out = ACC_W'(acc_clamp);

        prod_p = PPROD_W'($signed({1'b0, cfg.prop_gain})) * PPROD_W'(err);
        prod_i = IPROD_W'($signed({1'b0, cfg.integ_gain})) * IPROD_W'(acc_out);
        wsum   = WSUM_W'(prod_p) + WSUM_W'(prod_i);

        // arithmetic shift rounds toward minus infinity
        shifted  = wsum >>> cfg.frac_shift;
        duty_lim = $signed(WSUM_W'({1'b0, cfg.duty_max}));
        if (shifted < 0)
            duty = '0;
        else if (shifted > duty_lim)
            duty = cfg.duty_max;
        else
            duty = DUTY_W'(shifted);

        status = CMP_W'(sample) > CMP_W'(cfg.status_threshold);
    end

endmodule

// ===== rtl/pi_duty_controller.sv =====
// ----------------------------------------------------------------------------
// pi_duty_controller
// A word accepted into the input stage passes through the control law into the
// result stage, where it is presented on duty and status_ok.
// Throughput: one word per cycle unless out_ready stalls the result stage;
// the integral loop (add, clamp) is combinational, the multiplies and shift follow it.
// Reset: rst_n clears both stage valids and the integral to zero and loads
// the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pi_duty_controller
    import pdc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] feedback_sample,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DUTY_W-1:0]      duty,
    output logic                   status_ok,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    pdc_cfg_t cfg;

    // Input stage: sample register and its valid.
    logic                    in_vld_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;

    // Result stage: registered duty and status.
    logic                    out_vld_reg;
    logic [DUTY_W-1:0]       duty_reg;
    logic                    status_reg;

    // Integral state, updated as a word moves into the result stage.
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;

    logic [DUTY_W-1:0]       duty_next;
    logic                    status_next;

    logic                    out_adv;
    logic                    in_take;
    logic                    move;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    pdc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pdc_law u_law (
        .sample  (sample_reg),
        .acc_in  (acc_reg),
        .cfg     (cfg),
        .acc_out (acc_next),
        .duty    (duty_next),
        .status  (status_next)
    );

    // The result stage can load when empty or when its word is taken;
    // the input stage can load when empty or when it advances.
    assign out_adv  = !out_vld_reg || out_ready;
    assign in_ready = !in_vld_reg || out_adv;
    assign in_take  = in_valid && in_ready;
    assign move     = in_vld_reg && out_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (out_adv)
                out_vld_reg <= in_vld_reg;
            if (move)
                acc_reg <= acc_next;
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
            sample_reg <= feedback_sample;
        if (move)
        begin
            duty_reg   <= duty_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign duty      = duty_reg;
    assign status_ok = status_reg;

    // A stalled input stage keeps its sample.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_adv) |=> (in_vld_reg && $stable(sample_reg)))
        else $error("input stage lost or changed a stalled sample");

    // The integral moves only when a word passes into the result stage.
    a_acc_move: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(acc_reg) |-> $past(move))
        else $error("integral changed without a word advancing");

    // A word that advances always lands in the result stage.
    a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_vld_reg)
        else $error("advanced word did not reach the result stage");

endmodule
